### rtl/core/ipatp_pkg.sv
// Shared types and character constants for the IP address text parser.
// No dependencies; every other file in rtl/core refers to this package.
`default_nettype none

package ipatp_pkg;

    // ASCII codes the parsers look for
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LOW_A   = 8'h61;
    localparam logic [7:0] CHAR_LOW_F   = 8'h66;
    localparam logic [7:0] CHAR_UP_A    = 8'h41;
    localparam logic [7:0] CHAR_UP_F    = 8'h46;

    localparam int unsigned NUM_GROUPS  = 8;
    localparam int unsigned V4_OCTETS   = 4;

    // Verdict of one parser for the string in progress
    typedef enum logic [1:0] {
        OUT_PENDING,
        OUT_MATCH,
        OUT_FAIL
    } outcome_t;

    // One character as it is handed to both parsers
    typedef struct packed {
        logic       fire;       // item accepted this cycle
        logic       last_char;  // final character of the string
        logic [7:0] char_code;
    } char_feed_t;

    typedef logic [NUM_GROUPS-1:0][15:0] group_array_t;

    typedef struct packed {
        logic        match;
        logic [31:0] value;
    } v4_result_t;

    typedef struct packed {
        logic         match;
        group_array_t groups;   // index 0 is the most significant group
    } v6_result_t;

endpackage

`default_nettype wire

### rtl/core/ipatp_v4.sv
// Dotted-decimal IPv4 parser: running octet state plus end-of-string verdict.
// Depends on ipatp_pkg.
`default_nettype none

module ipatp_v4 (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ipatp_pkg::char_feed_t  feed,
    output ipatp_pkg::v4_result_t       result
);

    typedef enum logic {
        V4_EXPECT,
        V4_OCTET
    } v4_phase_t;

    v4_phase_t              phase_reg, phase_next;
    logic [7:0]             octet_reg, octet_next;
    logic [2:0]             count_reg, count_next;
    logic [31:0]            accum_reg, accum_next;
    ipatp_pkg::outcome_t    outcome_reg, outcome_next;

    logic                   dec_char;
    logic [7:0]             digit_val;
    logic [11:0]            octet_prod;
    logic [2:0]             close_count;
    logic [2:0]             fin_count;
    logic [31:0]            fin_accum;
    ipatp_pkg::outcome_t    fin_outcome;

    assign dec_char    = (feed.char_code >= ipatp_pkg::CHAR_ZERO) &&
                         (feed.char_code <= ipatp_pkg::CHAR_NINE);
    assign digit_val   = feed.char_code - ipatp_pkg::CHAR_ZERO;
    assign octet_prod  = 12'(octet_reg) * 12'd10 + 12'(digit_val[3:0]);
    assign close_count = count_reg + 3'd1;

    // Per-character step
    always_comb
    begin
        phase_next   = phase_reg;
        octet_next   = octet_reg;
        count_next   = count_reg;
        accum_next   = accum_reg;
        outcome_next = outcome_reg;
        if (outcome_reg == ipatp_pkg::OUT_PENDING)
        begin
            if (phase_reg != V4_OCTET)
            begin
                if (dec_char)
                begin
                    octet_next = digit_val;
                    phase_next = V4_OCTET;
                end
                else
                begin
                    outcome_next = ipatp_pkg::OUT_FAIL;
                end
            end
            else if (dec_char)
            begin
                if (octet_prod > 12'd255)
                    outcome_next = ipatp_pkg::OUT_FAIL;
                else
                    octet_next = octet_prod[7:0];
            end
            else
            begin
                // Any non-digit closes the octet
                accum_next = {accum_reg[23:0], octet_reg};
                count_next = close_count;
                if (close_count >= 3'(ipatp_pkg::V4_OCTETS))
                    outcome_next = ipatp_pkg::OUT_MATCH;
                else if (feed.char_code == ipatp_pkg::CHAR_DOT)
                    phase_next = V4_EXPECT;
                else
                    outcome_next = ipatp_pkg::OUT_FAIL;
            end
        end
    end

    // End of string: close an open octet and settle the verdict
    always_comb
    begin
        fin_outcome = outcome_next;
        fin_accum   = accum_next;
        fin_count   = count_next + 3'd1;
        if (outcome_next == ipatp_pkg::OUT_PENDING)
        begin
            if (phase_next == V4_OCTET)
            begin
                fin_accum   = {accum_next[23:0], octet_next};
                fin_outcome = (fin_count >= 3'(ipatp_pkg::V4_OCTETS)) ?
                              ipatp_pkg::OUT_MATCH : ipatp_pkg::OUT_FAIL;
            end
            else
            begin
                fin_outcome = ipatp_pkg::OUT_FAIL;
            end
        end
    end

    assign result.match = (fin_outcome == ipatp_pkg::OUT_MATCH);
    assign result.value = fin_accum;

    // State; the last character of a string returns everything to reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= V4_EXPECT;
            octet_reg   <= '0;
            count_reg   <= '0;
            accum_reg   <= '0;
            outcome_reg <= ipatp_pkg::OUT_PENDING;
        end
        else if (feed.fire)
        begin
            if (feed.last_char)
            begin
                phase_reg   <= V4_EXPECT;
                octet_reg   <= '0;
                count_reg   <= '0;
                accum_reg   <= '0;
                outcome_reg <= ipatp_pkg::OUT_PENDING;
            end
            else
            begin
                phase_reg   <= phase_next;
                octet_reg   <= octet_next;
                count_reg   <= count_next;
                accum_reg   <= accum_next;
                outcome_reg <= outcome_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/ipatp_v6.sv
// IPv6 parser: hex group state, head group file and right-aligned tail shift line.
// Depends on ipatp_pkg.
`default_nettype none

module ipatp_v6 (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ipatp_pkg::char_feed_t  feed,
    output ipatp_pkg::v6_result_t       result
);

    typedef enum logic [2:0] {
        V6_START,
        V6_START_COLON,
        V6_HEAD_DIGITS,
        V6_HEAD_COLON,
        V6_TAIL_EXPECT,
        V6_TAIL_DIGITS
    } v6_phase_t;

    // Returns {is_hex, nibble}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = '0;
            if (c >= ipatp_pkg::CHAR_ZERO && c <= ipatp_pkg::CHAR_NINE)
            begin
                d = c - ipatp_pkg::CHAR_ZERO;
                hex_nibble = {1'b1, d[3:0]};
            end
            else if (c >= ipatp_pkg::CHAR_LOW_A && c <= ipatp_pkg::CHAR_LOW_F)
            begin
                d = c - ipatp_pkg::CHAR_LOW_A + 8'd10;
                hex_nibble = {1'b1, d[3:0]};
            end
            else if (c >= ipatp_pkg::CHAR_UP_A && c <= ipatp_pkg::CHAR_UP_F)
            begin
                d = c - ipatp_pkg::CHAR_UP_A + 8'd10;
                hex_nibble = {1'b1, d[3:0]};
            end
            else
            begin
                hex_nibble = 5'd0;
            end
        end
    endfunction

    v6_phase_t              phase_reg, phase_next;
    logic [15:0]            gv_reg, gv_next;
    logic [2:0]             dc_reg, dc_next;
    logic [3:0]             hc_reg, hc_next;
    logic [3:0]             tc_reg, tc_next;
    ipatp_pkg::outcome_t    outcome_reg, outcome_next;

    ipatp_pkg::group_array_t head_reg;
    ipatp_pkg::group_array_t tail_reg;   // tail groups packed toward index 7

    logic [4:0]             hex_code;
    logic                   is_hex;
    logic [3:0]             nib;
    logic                   is_colon;
    logic                   can_extend;
    logic [15:0]            gv_shift;
    logic                   push_h, push_t;
    logic                   fin_push_h, fin_push_t;
    logic                   any_push_h, any_push_t;
    logic [15:0]            push_val;
    logic [3:0]             hc_eff, tc_eff;
    ipatp_pkg::outcome_t    fin_outcome;
    ipatp_pkg::group_array_t head_eff;
    ipatp_pkg::group_array_t tail_eff;
    ipatp_pkg::group_array_t groups_out;

    assign hex_code   = hex_nibble(feed.char_code);
    assign is_hex     = hex_code[4];
    assign nib        = hex_code[3:0];
    assign is_colon   = (feed.char_code == ipatp_pkg::CHAR_COLON);
    assign can_extend = is_hex && (dc_reg < 3'd4);
    assign gv_shift   = {gv_reg[11:0], nib};

    // Per-character step
    always_comb
    begin
        phase_next   = phase_reg;
        gv_next      = gv_reg;
        dc_next      = dc_reg;
        outcome_next = outcome_reg;
        push_h       = 1'b0;
        push_t       = 1'b0;
        if (outcome_reg == ipatp_pkg::OUT_PENDING)
        begin
            case (phase_reg)
                V6_START:
                begin
                    if (is_colon)
                    begin
                        phase_next = V6_START_COLON;
                    end
                    else if (is_hex)
                    begin
                        gv_next    = 16'(nib);
                        dc_next    = 3'd1;
                        phase_next = V6_HEAD_DIGITS;
                    end
                    else
                    begin
                        outcome_next = ipatp_pkg::OUT_FAIL;
                    end
                end
                V6_START_COLON:
                begin
                    if (is_colon)
                        phase_next = V6_TAIL_EXPECT;
                    else
                        outcome_next = ipatp_pkg::OUT_FAIL;
                end
                V6_HEAD_DIGITS:
                begin
                    if (can_extend)
                    begin
                        gv_next = gv_shift;
                        dc_next = dc_reg + 3'd1;
                    end
                    else
                    begin
                        push_h = 1'b1;
                        if (hc_reg + 4'd1 >= 4'(ipatp_pkg::NUM_GROUPS))
                            outcome_next = ipatp_pkg::OUT_MATCH;
                        else if (is_colon)
                            phase_next = V6_HEAD_COLON;
                        else
                            outcome_next = ipatp_pkg::OUT_FAIL;
                    end
                end
                V6_HEAD_COLON:
                begin
                    if (is_colon)
                    begin
                        phase_next = V6_TAIL_EXPECT;
                    end
                    else if (is_hex)
                    begin
                        gv_next    = 16'(nib);
                        dc_next    = 3'd1;
                        phase_next = V6_HEAD_DIGITS;
                    end
                    else
                    begin
                        outcome_next = ipatp_pkg::OUT_FAIL;
                    end
                end
                V6_TAIL_EXPECT:
                begin
                    if (is_hex)
                    begin
                        gv_next    = 16'(nib);
                        dc_next    = 3'd1;
                        phase_next = V6_TAIL_DIGITS;
                    end
                    else
                    begin
                        outcome_next = ipatp_pkg::OUT_MATCH;
                    end
                end
                V6_TAIL_DIGITS:
                begin
                    if (can_extend)
                    begin
                        gv_next = gv_shift;
                        dc_next = dc_reg + 3'd1;
                    end
                    else
                    begin
                        // A tail closes as a match unless a colon asks for more and a group is still free
                        push_t = 1'b1;
                        if ((hc_reg + tc_reg + 4'd1 < 4'(ipatp_pkg::NUM_GROUPS)) &&
                            is_colon)
                            phase_next = V6_TAIL_EXPECT;
                        else
                            outcome_next = ipatp_pkg::OUT_MATCH;
                    end
                end
                default:
                begin
                    outcome_next = ipatp_pkg::OUT_FAIL;
                end
            endcase
        end
    end

    assign hc_next = hc_reg + 4'(push_h);
    assign tc_next = tc_reg + 4'(push_t);

    // End of string; at most one group is pushed per character overall
    always_comb
    begin
        fin_outcome = outcome_next;
        fin_push_h  = 1'b0;
        fin_push_t  = 1'b0;
        if (outcome_next == ipatp_pkg::OUT_PENDING)
        begin
            case (phase_next)
                V6_HEAD_DIGITS:
                begin
                    fin_push_h  = 1'b1;
                    fin_outcome = (hc_reg + 4'd1 >= 4'(ipatp_pkg::NUM_GROUPS)) ?
                                  ipatp_pkg::OUT_MATCH : ipatp_pkg::OUT_FAIL;
                end
                V6_TAIL_EXPECT:
                begin
                    fin_outcome = ipatp_pkg::OUT_MATCH;
                end
                V6_TAIL_DIGITS:
                begin
                    fin_push_t  = 1'b1;
                    fin_outcome = ipatp_pkg::OUT_MATCH;
                end
                default:
                begin
                    fin_outcome = ipatp_pkg::OUT_FAIL;
                end
            endcase
        end
    end

    assign any_push_h = push_h | fin_push_h;
    assign any_push_t = push_t | fin_push_t;
    assign push_val   = (push_h | push_t) ? gv_reg : gv_next;
    assign hc_eff     = hc_reg + 4'(any_push_h);
    assign tc_eff     = tc_reg + 4'(any_push_t);

    // Group files as they stand once this character's push lands
    always_comb
    begin
        for (int k = 0; k < ipatp_pkg::NUM_GROUPS; k++)
        begin
            head_eff[k] = (any_push_h && (hc_reg[2:0] == 3'(k))) ? push_val : head_reg[k];
            if (!any_push_t)
                tail_eff[k] = tail_reg[k];
            else if (k == ipatp_pkg::NUM_GROUPS - 1)
                tail_eff[k] = push_val;
            else
                tail_eff[k] = tail_reg[(k + 1) % ipatp_pkg::NUM_GROUPS];
        end
    end

    // Head groups from the left, tail groups from the right, zeros between
    always_comb
    begin
        for (int i = 0; i < ipatp_pkg::NUM_GROUPS; i++)
        begin
            if (4'(i) < hc_eff)
                groups_out[i] = head_eff[i];
            else if (4'(i) + tc_eff >= 4'(ipatp_pkg::NUM_GROUPS))
                groups_out[i] = tail_eff[i];
            else
                groups_out[i] = '0;
        end
    end

    assign result.groups = groups_out;
    assign result.match  = (fin_outcome == ipatp_pkg::OUT_MATCH);

    // Group storage; only entries covered by the counts are ever selected
    always_ff @(posedge clk)
    begin
        if (feed.fire && !feed.last_char)
        begin
            if (push_h)
                head_reg[hc_reg[2:0]] <= gv_reg;
            if (push_t)
                tail_reg <= {gv_reg, tail_reg[ipatp_pkg::NUM_GROUPS-1:1]};
        end
    end

    // Control state; the last character of a string returns it to reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= V6_START;
            gv_reg      <= '0;
            dc_reg      <= '0;
            hc_reg      <= '0;
            tc_reg      <= '0;
            outcome_reg <= ipatp_pkg::OUT_PENDING;
        end
        else if (feed.fire)
        begin
            if (feed.last_char)
            begin
                phase_reg   <= V6_START;
                gv_reg      <= '0;
                dc_reg      <= '0;
                hc_reg      <= '0;
                tc_reg      <= '0;
                outcome_reg <= ipatp_pkg::OUT_PENDING;
            end
            else
            begin
                phase_reg   <= phase_next;
                gv_reg      <= gv_next;
                dc_reg      <= dc_next;
                hc_reg      <= hc_next;
                tc_reg      <= tc_next;
                outcome_reg <= outcome_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/ip_address_text_parser_unit.sv
// IP address text parser, top level: both parsers, result select and output register.
// Depends on ipatp_pkg, ipatp_v4 and ipatp_v6.
//
// Takes an address string one ASCII character per item (last_char marks the end)
// and returns one result per string: parse_ok, is_ipv6 and either the IPv4 value or
// the eight IPv6 groups, with IPv4 taking precedence when both forms match. One
// character is taken every cycle; the result is presented in the cycle after the
// last character is accepted and sits in a single output register. Characters that
// are not the last one keep flowing while a result waits; a last character is held
// off only while the previous result is still stalled.
`default_nettype none

module ip_address_text_parser_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         char_valid,
    output      logic         char_stall,
    input  wire logic [7:0]   char_code,
    input  wire logic         last_char,
    output      logic         result_valid,
    input  wire logic         result_stall,
    output      logic         parse_ok,
    output      logic         is_ipv6,
    output      logic [31:0]  ipv4_value,
    output      logic [15:0]  group_0,
    output      logic [15:0]  group_1,
    output      logic [15:0]  group_2,
    output      logic [15:0]  group_3,
    output      logic [15:0]  group_4,
    output      logic [15:0]  group_5,
    output      logic [15:0]  group_6,
    output      logic [15:0]  group_7
);

    ipatp_pkg::char_feed_t   feed;
    ipatp_pkg::v4_result_t   v4_res;
    ipatp_pkg::v6_result_t   v6_res;

    logic                    char_fire;
    logic                    out_load;
    logic                    valid_reg, valid_next;
    logic                    ok_reg, ok_next;
    logic                    v6_reg, v6_next;
    logic [31:0]             v4_val_reg, v4_val_next;
    ipatp_pkg::group_array_t groups_reg, groups_next;

    // Handshake: only a last character needs room in the output register
    assign char_stall = valid_reg && result_stall && last_char;
    assign char_fire  = char_valid && !char_stall;
    assign out_load   = char_fire && last_char;

    assign feed.fire      = char_fire;
    assign feed.last_char = last_char;
    assign feed.char_code = char_code;

    ipatp_v4 u_v4 (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed),
        .result (v4_res)
    );

    ipatp_v6 u_v6 (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed),
        .result (v6_res)
    );

    // Result select: IPv4 first, unused fields read as zero
    always_comb
    begin
        ok_next     = 1'b0;
        v6_next     = 1'b0;
        v4_val_next = '0;
        groups_next = '0;
        if (v4_res.match)
        begin
            ok_next     = 1'b1;
            v4_val_next = v4_res.value;
        end
        else if (v6_res.match)
        begin
            ok_next     = 1'b1;
            v6_next     = 1'b1;
            groups_next = v6_res.groups;
        end
    end

    assign valid_next = out_load || (valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ok_reg     <= ok_next;
            v6_reg     <= v6_next;
            v4_val_reg <= v4_val_next;
            groups_reg <= groups_next;
        end
    end

    assign result_valid = valid_reg;
    assign parse_ok     = ok_reg;
    assign is_ipv6      = v6_reg;
    assign ipv4_value   = v4_val_reg;
    assign group_0      = groups_reg[0];
    assign group_1      = groups_reg[1];
    assign group_2      = groups_reg[2];
    assign group_3      = groups_reg[3];
    assign group_4      = groups_reg[4];
    assign group_5      = groups_reg[5];
    assign group_6      = groups_reg[6];
    assign group_7      = groups_reg[7];

    // A non-final character never produces a result
    a_no_result_mid_string: assert property (@(posedge clk) disable iff (!rst_n)
        (char_fire && !last_char && !valid_reg) |=> !result_valid)
        else $error("result appeared after a non-final character");

    // A final character always produces a result next cycle
    a_result_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (char_fire && last_char) |=> result_valid)
        else $error("no result after a final character");

    // A failed parse reports no family and no IPv4 address
    a_fail_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !parse_ok) |-> (!is_ipv6 && (ipv4_value == 32'd0)))
        else $error("failed parse carries address data");

    // An IPv6 result leaves the IPv4 field clear
    a_v6_clears_v4: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && is_ipv6) |-> (parse_ok && (ipv4_value == 32'd0)))
        else $error("IPv6 result with IPv4 data");

endmodule

`default_nettype wire
